>>> hdl/tsoq_pkg.sv
// ----------------------------------------------------------------------------
// tsoq_pkg: shared types and constants
// Payload structs, result codes and controller/datapath interface types
// for the time-sorted order queue.
// ----------------------------------------------------------------------------
package tsoq_pkg;

  // Input command codes
  localparam logic CMD_ENQ   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Result kind codes
  localparam logic [1:0] KIND_ENQ     = 2'd0;
  localparam logic [1:0] KIND_DROP    = 2'd1;
  localparam logic [1:0] KIND_FLUSHED = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef struct packed {
    logic        command;
    logic [15:0] order_id;
    logic [31:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] order_id_res;
    logic [31:0] order_time;
    logic        last;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_t;

  // Source of the id/time fields of a result
  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_TAIL,
    SEL_ZERO
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic       ins_en;    // insert the input entry into the cells
    logic       pop_en;    // drop the tail entry
    logic       thr_load;  // capture the flush threshold
    logic       out_load;  // load the result register
    out_sel_t   out_sel;
    logic [1:0] out_kind;
    logic       out_last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;        // every slot holds an entry
    logic tail_match;  // oldest entry is at or before the threshold
    logic tail_last;   // no further entry matches after the tail
  } dp_status_t;

endpackage

>>> hdl/tsoq_datapath.sv
// ----------------------------------------------------------------------------
// tsoq_datapath: sorted cell array and result register
// Row of entry cells kept newest first, with a compare in every cell for
// insertion and flush matching, a fill count and the result register.
// ----------------------------------------------------------------------------
module tsoq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsoq_pkg::in_item_t   in_data,
  input  tsoq_pkg::ctrl_cmd_t  cmd,
  output tsoq_pkg::dp_status_t status,
  output tsoq_pkg::out_item_t  out_data
);
  import tsoq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [15:0]   ids_r   [DEPTH];
  logic [31:0]   times_r [DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   thr_r;
  out_item_t     out_r;

  logic [DEPTH-1:0] newer;    // stored entry is strictly newer than the input
  logic [DEPTH-1:0] matched;  // stored entry is at or before the threshold
  logic [CW-1:0]    cnt_m1, cnt_m2;
  logic [15:0]      tail_id;
  logic [31:0]      tail_time;

  // Per-cell compares
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      newer[i]   = (CW'(i) < cnt_r) && (in_data.stamp < times_r[i]);
      matched[i] = (CW'(i) < cnt_r) && !(thr_r < times_r[i]);
    end
  end

  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_m2    = cnt_r - CW'(2);
  assign tail_id   = ids_r[cnt_m1[IW-1:0]];
  assign tail_time = times_r[cnt_m1[IW-1:0]];

  assign status.full       = (cnt_r == CW'(DEPTH));
  assign status.tail_match = (cnt_r != '0) && matched[cnt_m1[IW-1:0]];
  assign status.tail_last  = (cnt_r == CW'(1)) || !matched[cnt_m2[IW-1:0]];

  // Cells: take the new entry at the insertion point, shift older ones back
  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.ins_en && !newer[0]) begin
          ids_r[0]   <= in_data.order_id;
          times_r[0] <= in_data.stamp;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (cmd.ins_en && !newer[g]) begin
          if (newer[g-1]) begin
            ids_r[g]   <= in_data.order_id;
            times_r[g] <= in_data.stamp;
          end else begin
            ids_r[g]   <= ids_r[g-1];
            times_r[g] <= times_r[g-1];
          end
        end
      end
    end
  end

  // Fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop_en) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Threshold and result register
  always_ff @(posedge clk) begin
    if (cmd.thr_load) begin
      thr_r <= in_data.stamp;
    end
    if (cmd.out_load) begin
      out_r.kind <= cmd.out_kind;
      out_r.last <= cmd.out_last;
      case (cmd.out_sel)
        SEL_INPUT: begin
          out_r.order_id_res <= in_data.order_id;
          out_r.order_time   <= in_data.stamp;
        end
        SEL_TAIL: begin
          out_r.order_id_res <= tail_id;
          out_r.order_time   <= tail_time;
        end
        default: begin
          out_r.order_id_res <= '0;
          out_r.order_time   <= '0;
        end
      endcase
    end
  end

  assign out_data = out_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count above depth");
  a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |-> !status.full)
    else $error("insert into full queue");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_en |=> cnt_r == $past(cnt_m1))
    else $error("pop did not shrink the queue by one");
  a_pop_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_en |-> status.tail_match)
    else $error("pop of a non-matching tail");

endmodule

>>> hdl/tsoq_ctrl.sv
// ----------------------------------------------------------------------------
// tsoq_ctrl: queue controller
// Handshake control, flush sequencing and output valid register.
// ----------------------------------------------------------------------------
module tsoq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tsoq_pkg::dp_status_t status,
  output tsoq_pkg::ctrl_cmd_t  cmd
);
  import tsoq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.ins_en   = 1'b0;
    cmd.pop_en   = 1'b0;
    cmd.thr_load = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_sel  = SEL_INPUT;
    cmd.out_kind = KIND_ENQ;
    cmd.out_last = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (in_command == CMD_ENQ) begin
            cmd.out_load = 1'b1;
            cmd.ins_en   = !status.full;
            cmd.out_kind = status.full ? KIND_DROP : KIND_ENQ;
          end else begin
            cmd.thr_load = 1'b1;
            state_nxt    = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // Tail entries leave oldest first; a miss can only be the first look
        if (slot_free) begin
          cmd.out_load = 1'b1;
          if (status.tail_match) begin
            cmd.pop_en   = 1'b1;
            cmd.out_sel  = SEL_TAIL;
            cmd.out_kind = KIND_FLUSHED;
            cmd.out_last = status.tail_last;
            if (status.tail_last) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            cmd.out_sel  = SEL_ZERO;
            cmd.out_kind = KIND_NONE;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> !in_ready)
    else $error("input taken during flush");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("pending result overwritten");

endmodule

>>> hdl/time_sorted_order_queue.sv
// Enqueue: result presented the cycle after the transfer; one enqueue per cycle
//   while results are taken. Insertion is a parallel compare in every cell.
// Flush: the threshold is captured first, then one removed entry per cycle while results
//   are taken, oldest first; with no match a single nothing-found result is given.
// Reset (rst_n, synchronous): empties the queue and clears handshake state;
//   entry storage is not cleared.
// ----------------------------------------------------------------------------
// time_sorted_order_queue: top level
// Bounded queue of (id, time) entries kept newest first, with enqueue and
// threshold flush commands.
// ----------------------------------------------------------------------------
module time_sorted_order_queue #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsoq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tsoq_pkg::out_item_t out_data
);
  import tsoq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tsoq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  tsoq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

>>> test/time_sorted_order_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_sorted_order_queue_test: self-checking bench for the order queue
// Drives enqueue and flush commands over the valid/ready input channel and
// checks every result transfer against a typed table result or a behavioural
// copy of the sorted queue. A short stimulus table covers the corner cases,
// then random command bursts run under four sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module time_sorted_order_queue_test;
  import tsoq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 20;
  localparam int RAND_ITEMS  = 46;  // per idling phase

  // One row of the directed table; the wanted result is only used when typed
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow copy of the queue contents, newest first
  logic [15:0] shadow_ids[DEPTH];
  logic [31:0] shadow_times[DEPTH];
  int          shadow_fill = 0;

  out_item_t   fresh_results[$];
  out_item_t   awaited_results[$];
  stim_row_t   stim_table[$];

  int          err_count      = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          burst_left     = 0;

  time_sorted_order_queue #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at cycle %0d: %s expected %0h got %0h",
             cycle_count, what, want, got);
    err_count++;
  endtask

  // Sorted insert or threshold flush; results land in fresh_results
  function automatic void apply_order(input in_item_t item);
    int        pos;
    int        i;
    out_item_t res;
    fresh_results.delete();
    pos = 0;
    while (pos < shadow_fill && item.stamp < shadow_times[pos]) pos++;
    if (item.command == CMD_ENQ) begin
      if (shadow_fill >= DEPTH) begin
        res = '{KIND_DROP, item.order_id, item.stamp, 1'b1};
        fresh_results.push_back(res);
        return;
      end
      for (i = shadow_fill; i > pos; i--) begin
        shadow_ids[i]   = shadow_ids[i-1];
        shadow_times[i] = shadow_times[i-1];
      end
      shadow_ids[pos]   = item.order_id;
      shadow_times[pos] = item.stamp;
      shadow_fill++;
      res = '{KIND_ENQ, item.order_id, item.stamp, 1'b1};
      fresh_results.push_back(res);
    end else if (pos >= shadow_fill) begin
      res = '{KIND_NONE, 16'h0000, 32'h0000_0000, 1'b1};
      fresh_results.push_back(res);
    end else begin
      // matching entries are the tail; oldest goes out first
      for (i = shadow_fill - 1; i >= pos; i--) begin
        res = '{KIND_FLUSHED, shadow_ids[i], shadow_times[i], i == pos};
        fresh_results.push_back(res);
      end
      shadow_fill = pos;
    end
  endfunction

  // Directed row; typed results echo the input, a nothing-found flush is zero
  function automatic void add_row(input logic cmd, input logic [15:0] id,
                                  input logic [31:0] stamp, input logic typed,
                                  input logic [1:0] kind);
    stim_row_t row;
    row.item  = '{cmd, id, stamp};
    row.typed = typed;
    if (kind == KIND_NONE)
      row.want = '{kind, 16'h0000, 32'h0000_0000, 1'b1};
    else
      row.want = '{kind, id, stamp, 1'b1};
    stim_table.push_back(row);
  endfunction

  function automatic void build_table();
    int k;
    // flush of an empty queue, then extremes and an equal-time pair
    add_row(CMD_FLUSH, 16'hABCD, 32'hFFFF_FFFF, 1'b1, KIND_NONE);
    add_row(CMD_ENQ,   16'h0000, 32'h0000_0000, 1'b1, KIND_ENQ);
    add_row(CMD_ENQ,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, KIND_ENQ);
    add_row(CMD_ENQ,   16'h1234, 32'd100,       1'b1, KIND_ENQ);
    add_row(CMD_ENQ,   16'h0005, 32'd100,       1'b1, KIND_ENQ);
    // partial flushes: one entry, nothing, then the equal-time pair
    add_row(CMD_FLUSH, 16'h5555, 32'd99,        1'b0, KIND_FLUSHED);
    add_row(CMD_FLUSH, 16'h0000, 32'h0000_0000, 1'b1, KIND_NONE);
    add_row(CMD_FLUSH, 16'hAAAA, 32'd100,       1'b0, KIND_FLUSHED);
    // fill up, with repeated times among the entries
    for (k = 0; k < DEPTH - 1; k++)
      add_row(CMD_ENQ, 16'h0100 + 16'(k), 32'd200 + 32'((k * 7) % 5) * 1000,
              1'b0, KIND_ENQ);
    // full queue drops, then flush everything out
    add_row(CMD_ENQ,   16'hFFFF, 32'h0000_0000, 1'b1, KIND_DROP);
    add_row(CMD_ENQ,   16'h0000, 32'hFFFF_FFFF, 1'b1, KIND_DROP);
    add_row(CMD_FLUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, KIND_FLUSHED);
  endfunction

  // Mostly bursts of enqueues closed by a flush, with some random commands
  function automatic in_item_t rand_order();
    in_item_t item;
    if ($urandom_range(99) < 10) begin
      item.command = 1'($urandom_range(1));
    end else if (burst_left > 0) begin
      item.command = CMD_ENQ;
      burst_left--;
    end else begin
      item.command = CMD_FLUSH;
      burst_left   = $urandom_range(1, 20);
    end
    item.order_id = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(3))
      0, 1:    item.stamp = $urandom_range(40);
      2:       item.stamp = $urandom();
      default: item.stamp = 32'hFFFF_FFFF - $urandom_range(40);
    endcase
    return item;
  endfunction

  // One input transfer; the prediction is taken at the accepting edge
  task automatic send_item(input in_item_t item, input logic typed,
                           input out_item_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_order(item);
    if (typed)
      awaited_results.push_back(want);
    else
      foreach (fresh_results[j]) awaited_results.push_back(fresh_results[j]);
  endtask

  // Hold off the sender until every awaited result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Result checking and receiver stalls
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result kind", 32'hFFFF_FFFF,
                        32'(out_data.kind));
      end else begin
        want = awaited_results.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch("kind", 32'(want.kind), 32'(out_data.kind));
        if (out_data.order_id_res !== want.order_id_res)
          report_mismatch("order_id_res", 32'(want.order_id_res),
                          32'(out_data.order_id_res));
        if (out_data.order_time !== want.order_time)
          report_mismatch("order_time", want.order_time, out_data.order_time);
        if (out_data.last !== want.last)
          report_mismatch("last", 32'(want.last), 32'(out_data.last));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Main sequence
  initial begin
    int phase;
    build_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    foreach (stim_table[r])
      send_item(stim_table[r].item, stim_table[r].typed, stim_table[r].want);

    // random bursts under each idling pattern
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      drain_results();
      repeat (RAND_ITEMS) send_item(rand_order(), 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> time_sorted_order_queue.f
hdl/tsoq_pkg.sv
hdl/tsoq_datapath.sv
hdl/tsoq_ctrl.sv
hdl/time_sorted_order_queue.sv
test/time_sorted_order_queue_test.sv
